>>> hw/rtl/assert_macros.svh
// Assertion macros for the solver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked on every clock edge outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> hw/rtl/cts_pkg.sv
// Package with types, constants and status codes of the 3x3 solver.
package cts_pkg;
  localparam int WordBits = 32;
  localparam int FracBits = 16;
  localparam int ProdBits = 3 * WordBits;
  localparam int DetBits = ProdBits + 3;
  localparam int NumBits = DetBits + FracBits;
  localparam int QuoBits = NumBits;
  localparam int SlcBits = 5;
  localparam int DivStages = (QuoBits + 7) / 8;
  localparam int StepsPerStage = 8;
  localparam int DivSteps = DivStages * StepsPerStage;

  typedef logic signed [WordBits-1:0] word_t;
  typedef logic signed [DetBits-1:0] det_t;
  typedef logic [DetBits-1:0] mag_t;
  typedef logic [DivSteps-1:0] quo_t;

  typedef enum logic [1:0] {
    STATUS_UNIQUE = 2'd0,
    STATUS_INFINITE = 2'd1,
    STATUS_NONE = 2'd2
  } status_t;

  typedef struct packed {
    word_t a11; word_t a12; word_t a13; word_t b1;
    word_t a21; word_t a22; word_t a23; word_t b2;
    word_t a31; word_t a32; word_t a33; word_t b3;
  } sys_t;

  typedef struct packed {
    word_t x_value;
    word_t y_value;
    word_t z_value;
    status_t status;
    logic saturated;
  } sol_t;

  // Per-item sideband that follows a quotient through the divider.
  typedef struct packed {
    logic [2:0] neg;
    status_t status;
  } side_t;
endpackage

>>> hw/rtl/cts_if.sv
// Valid/ready channel interfaces for systems and solutions.
interface cts_sys_if (input logic clk);
  import cts_pkg::*;
  logic valid;
  logic ready;
  sys_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cts_sol_if (input logic clk);
  import cts_pkg::*;
  logic valid;
  logic ready;
  sol_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/cramer_three_by_three_solver_unit.sv
// Top level of the pipelined 3x3 Cramer's rule solver.
// The solver takes one 3x3 system per cycle and returns one solution per system
// in order. An item passes 5 determinant registers (operand register, pair
// products, split partial products, triple products, Sarrus sums), one classify
// register, 15 divider stages of eight quotient bits each, and an output register.
// Throughput is one item per cycle; a stall on the result side freezes the whole
// pipeline, input included, until the waiting result is taken.
module cramer_three_by_three_solver_unit (
  input logic clk,
  input logic rst_n,
  cts_sys_if.sink in_sys,
  cts_sol_if.source out_sol
);
  import cts_pkg::*;
  `include "assert_macros.svh"

  localparam logic [QuoBits-1:0] PosLim = QuoBits'((64'd1 << (WordBits - 1)) - 64'd1);
  localparam logic [QuoBits-1:0] NegLim = QuoBits'(64'd1 << (WordBits - 1));

  logic adv;
  logic det_vld;
  det_t dm, dx, dy, dz;
  logic div_vld;
  side_t side;
  quo_t quo [3];
  sol_t sol;
  logic out_vld_r;
  sol_t out_r;

  assign adv = !out_vld_r || out_sol.ready;
  assign in_sys.ready = adv;

  cts_det u_det (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(in_sys.valid), .sys(in_sys.data),
    .out_vld(det_vld), .det_main(dm), .det_x(dx), .det_y(dy), .det_z(dz)
  );

  cts_div u_div (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(det_vld), .det_main(dm),
    .det_x(dx), .det_y(dy), .det_z(dz), .out_vld(div_vld), .side(side), .quo(quo)
  );

  word_t val [3];
  logic [2:0] sat;
  logic [QuoBits-1:0] lim;
  always_comb begin
    lim = '0;
    for (int v = 0; v < 3; v++) begin
      lim = side.neg[v] ? NegLim : PosLim;
      sat[v] = quo[v][QuoBits-1:0] > lim;
      val[v] = sat[v] ? WordBits'(lim) : quo[v][WordBits-1:0];
      if (side.neg[v]) begin
        val[v] = -val[v];
      end
      if (side.status != STATUS_UNIQUE) begin
        val[v] = '0;
        sat[v] = 1'b0;
      end
    end
    sol.x_value = val[0];
    sol.y_value = val[1];
    sol.z_value = val[2];
    sol.status = side.status;
    sol.saturated = |sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= sol;
    end
  end

  assign out_sol.valid = out_vld_r;
  assign out_sol.data = out_r;

  `CHK_IMPLY(a_stall_blocks_input, clk, rst_n, out_vld_r && !out_sol.ready, !in_sys.ready,
             "input accepted while result stalled")
  `CHK_IMPLY(a_nonunique_zero, clk, rst_n,
             out_vld_r && out_r.status != STATUS_UNIQUE,
             out_r.x_value == '0 && out_r.y_value == '0 && out_r.z_value == '0
             && !out_r.saturated, "nonzero solution for singular system")
  `CHK_NEXT(a_stall_holds, clk, rst_n, out_vld_r && !out_sol.ready,
            out_vld_r && $stable(out_r), "stalled result changed")
endmodule

>>> hw/rtl/cts_det.sv
// Determinant pipeline: pair products, triple products, then Sarrus sums.
module cts_det (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic in_vld,
  input  cts_pkg::sys_t sys,
  output logic out_vld,
  output cts_pkg::det_t det_main,
  output cts_pkg::det_t det_x,
  output cts_pkg::det_t det_y,
  output cts_pkg::det_t det_z
);
  import cts_pkg::*;

  localparam int PairBits = 2 * WordBits;

  word_t m_r [3][4];
  logic signed [PairBits-1:0] pp_r [4][6];
  word_t tf_r [4][6];
  logic signed [PairBits:0] tl_r [4][6];
  logic signed [PairBits-1:0] th_r [4][6];
  logic signed [ProdBits-1:0] tp_r [4][6];
  det_t det_r [4];
  logic [4:0] vld_r;

  word_t m [3][4];
  word_t mat [4][3][3];
  word_t fa [4][6];
  word_t fb [4][6];
  word_t fc [4][6];

  always_comb begin
    m[0][0] = sys.a11; m[0][1] = sys.a12; m[0][2] = sys.a13; m[0][3] = sys.b1;
    m[1][0] = sys.a21; m[1][1] = sys.a22; m[1][2] = sys.a23; m[1][3] = sys.b2;
    m[2][0] = sys.a31; m[2][1] = sys.a32; m[2][2] = sys.a33; m[2][3] = sys.b3;
    for (int k = 0; k < 4; k++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          mat[k][r][c] = m_r[r][(c == k - 1) ? 3 : c];
        end
      end
      fa[k][0] = mat[k][0][0]; fb[k][0] = mat[k][1][1]; fc[k][0] = mat[k][2][2];
      fa[k][1] = mat[k][1][0]; fb[k][1] = mat[k][2][1]; fc[k][1] = mat[k][0][2];
      fa[k][2] = mat[k][2][0]; fb[k][2] = mat[k][0][1]; fc[k][2] = mat[k][1][2];
      fa[k][3] = mat[k][0][2]; fb[k][3] = mat[k][1][1]; fc[k][3] = mat[k][2][0];
      fa[k][4] = mat[k][1][2]; fb[k][4] = mat[k][2][1]; fc[k][4] = mat[k][0][0];
      fa[k][5] = mat[k][2][2]; fb[k][5] = mat[k][0][1]; fc[k][5] = mat[k][1][0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  // The pair product is split into an unsigned low word and a signed high word,
  // so each partial product is about one word by one word.
  always_ff @(posedge clk) begin
    if (adv) begin
      m_r <= m;
      for (int k = 0; k < 4; k++) begin
        for (int t = 0; t < 6; t++) begin
          pp_r[k][t] <= PairBits'(fa[k][t]) * PairBits'(fb[k][t]);
          tf_r[k][t] <= fc[k][t];
          tl_r[k][t] <= (PairBits+1)'($signed({1'b0, pp_r[k][t][WordBits-1:0]}))
                      * (PairBits+1)'(tf_r[k][t]);
          th_r[k][t] <= PairBits'($signed(pp_r[k][t][PairBits-1:WordBits]))
                      * PairBits'(tf_r[k][t]);
          tp_r[k][t] <= (ProdBits'(th_r[k][t]) <<< WordBits) + ProdBits'(tl_r[k][t]);
        end
        det_r[k] <= DetBits'(tp_r[k][0]) + DetBits'(tp_r[k][1])
                  + DetBits'(tp_r[k][2]) - DetBits'(tp_r[k][3])
                  - DetBits'(tp_r[k][4]) - DetBits'(tp_r[k][5]);
      end
    end
  end

  // The input register m_r is stage zero, ahead of four product and sum stages.
  assign out_vld = vld_r[4];
  assign det_main = det_r[0];
  assign det_x = det_r[1];
  assign det_y = det_r[2];
  assign det_z = det_r[3];
endmodule

>>> hw/rtl/cts_div.sv
// Pipelined restoring divider for three quotients, eight bits per stage.
module cts_div (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic in_vld,
  input  cts_pkg::det_t det_main,
  input  cts_pkg::det_t det_x,
  input  cts_pkg::det_t det_y,
  input  cts_pkg::det_t det_z,
  output logic out_vld,
  output cts_pkg::side_t side,
  output cts_pkg::quo_t quo [3]
);
  import cts_pkg::*;

  localparam int NBits = DivSteps;
  localparam int RBits = DetBits + 1;

  logic [DivStages:0] vld_r;
  side_t side_r [DivStages+1];
  mag_t den_r [DivStages+1];
  logic [NBits-1:0] num_r [DivStages+1][3];
  logic [RBits-1:0] rem_r [DivStages+1][3];

  det_t dv [3];
  side_t side0;
  mag_t den0;
  logic [NBits-1:0] num0 [3];
  logic [NBits-1:0] nn [DivStages][3];
  logic [RBits-1:0] rr [DivStages][3];
  logic [RBits-1:0] tr;

  always_comb begin
    dv[0] = det_x; dv[1] = det_y; dv[2] = det_z;
    den0 = det_main[DetBits-1] ? mag_t'(-det_main) : mag_t'(det_main);
    side0.status = STATUS_UNIQUE;
    if (det_main == '0) begin
      side0.status = (det_x == '0 && det_y == '0 && det_z == '0)
                     ? STATUS_INFINITE : STATUS_NONE;
    end
    for (int v = 0; v < 3; v++) begin
      side0.neg[v] = dv[v][DetBits-1] ^ det_main[DetBits-1];
      num0[v] = NBits'(dv[v][DetBits-1] ? mag_t'(-dv[v]) : mag_t'(dv[v])) << FracBits;
    end
  end

  always_comb begin
    tr = '0;
    for (int s = 0; s < DivStages; s++) begin
      for (int v = 0; v < 3; v++) begin
        nn[s][v] = num_r[s][v];
        rr[s][v] = rem_r[s][v];
        for (int b = 0; b < StepsPerStage; b++) begin
          tr = {rr[s][v][RBits-2:0], nn[s][v][NBits-1]};
          nn[s][v] = {nn[s][v][NBits-2:0], 1'b0};
          if (tr >= RBits'(den_r[s])) begin
            rr[s][v] = tr - RBits'(den_r[s]);
            nn[s][v][0] = 1'b1;
          end else begin
            rr[s][v] = tr;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DivStages-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side0;
      den_r[0] <= den0;
      for (int v = 0; v < 3; v++) begin
        num_r[0][v] <= num0[v];
        rem_r[0][v] <= '0;
      end
      for (int s = 0; s < DivStages; s++) begin
        side_r[s+1] <= side_r[s];
        den_r[s+1] <= den_r[s];
        for (int v = 0; v < 3; v++) begin
          num_r[s+1][v] <= nn[s][v];
          rem_r[s+1][v] <= rr[s][v];
        end
      end
    end
  end

  assign out_vld = vld_r[DivStages];
  assign side = side_r[DivStages];
  always_comb begin
    for (int v = 0; v < 3; v++) begin
      quo[v] = num_r[DivStages][v];
    end
  end
endmodule

>>> tb/sv/cramer_three_by_three_solver_unit_test.sv
// Testbench for the 3x3 Cramer's rule solver: directed and random systems checked against a predictor.
module cramer_three_by_three_solver_unit_test;
  import cts_pkg::*;

  typedef logic signed [127:0] big_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  int stall_left = 0;
  sol_t pending_solutions[$];

  cts_sys_if sys_ch (clk);
  cts_sol_if sol_ch (clk);

  cramer_three_by_three_solver_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_sys(sys_ch),
    .out_sol(sol_ch)
  );

  initial sys_ch.valid = 1'b0;
  initial sys_ch.data = '0;
  initial sol_ch.ready = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic big_t sarrus(big_t m[3][3]);
    return m[0][0] * m[1][1] * m[2][2] + m[1][0] * m[2][1] * m[0][2]
         + m[2][0] * m[0][1] * m[1][2] - m[0][2] * m[1][1] * m[2][0]
         - m[1][2] * m[2][1] * m[0][0] - m[2][2] * m[0][1] * m[1][0];
  endfunction

  function automatic sol_t solve_system(sys_t s);
    big_t coef[3][4];
    big_t m[3][3];
    big_t dets[4];
    big_t q;
    big_t hi;
    big_t lo;
    sol_t r;
    word_t vals[3];
    coef[0][0] = s.a11; coef[0][1] = s.a12; coef[0][2] = s.a13; coef[0][3] = s.b1;
    coef[1][0] = s.a21; coef[1][1] = s.a22; coef[1][2] = s.a23; coef[1][3] = s.b2;
    coef[2][0] = s.a31; coef[2][1] = s.a32; coef[2][2] = s.a33; coef[2][3] = s.b3;
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          m[i][j] = coef[i][(j == k - 1) ? 3 : j];
      dets[k] = sarrus(m);
    end
    r = '0;
    if (dets[0] == 0) begin
      r.status = (dets[1] == 0 && dets[2] == 0 && dets[3] == 0) ? STATUS_INFINITE : STATUS_NONE;
      return r;
    end
    hi = (big_t'(1) <<< (WordBits - 1)) - 1;
    lo = -(big_t'(1) <<< (WordBits - 1));
    for (int k = 0; k < 3; k++) begin
      q = (dets[k + 1] <<< FracBits) / dets[0];
      if (q > hi) begin
        q = hi;
        r.saturated = 1'b1;
      end else if (q < lo) begin
        q = lo;
        r.saturated = 1'b1;
      end
      vals[k] = q[WordBits-1:0];
    end
    r.x_value = vals[0];
    r.y_value = vals[1];
    r.z_value = vals[2];
    r.status = STATUS_UNIQUE;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("field %s: got %h, expected %h", field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    sol_t got;
    sol_t want;
    if (rst_n && sol_ch.valid && sol_ch.ready) begin
      got = sol_ch.data;
      if (pending_solutions.size() == 0) begin
        $display("solution arrived with none outstanding");
        errors++;
      end else begin
        want = pending_solutions.pop_front();
        if (got.x_value !== want.x_value) report_mismatch("x_value", got.x_value, want.x_value);
        if (got.y_value !== want.y_value) report_mismatch("y_value", got.y_value, want.y_value);
        if (got.z_value !== want.z_value) report_mismatch("z_value", got.z_value, want.z_value);
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.saturated !== want.saturated)
          report_mismatch("saturated", got.saturated, want.saturated);
      end
    end
  end

  always @(posedge clk) begin
    if (quiet) begin
      sol_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      sol_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      sol_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      sol_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 300000) begin
      $display("cramer_three_by_three_solver_unit: mismatch");
      $finish;
    end
  end

  task automatic send_system(sys_t s);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      sys_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    sys_ch.valid <= 1'b1;
    sys_ch.data <= s;
    do @(posedge clk); while (!sys_ch.ready);
    pending_solutions = {pending_solutions, solve_system(s)};
  endtask

  function automatic word_t fix(int v);
    return word_t'(v <<< FracBits);
  endfunction

  function automatic word_t rand_word(int kind);
    case (kind)
      0: return word_t'($urandom);
      1: return word_t'($urandom_range(0, 20 << FracBits)) - fix(10);
      2: return fix($urandom_range(0, 8) - 4);
      default: return word_t'($urandom_range(0, 64)) - 32;
    endcase
  endfunction

  function automatic sys_t rand_system(int kind);
    sys_t s;
    s = {rand_word(kind), rand_word(kind), rand_word(kind), rand_word(kind),
         rand_word(kind), rand_word(kind), rand_word(kind), rand_word(kind),
         rand_word(kind), rand_word(kind), rand_word(kind), rand_word(kind)};
    return s;
  endfunction

  task automatic test_identity_and_simple;
    sys_t s;
    s = '0;
    s.a11 = fix(1); s.a22 = fix(1); s.a33 = fix(1);
    s.b1 = fix(3); s.b2 = fix(-5); s.b3 = fix(7);
    send_system(s);
    s.a12 = fix(2); s.a21 = fix(-1); s.a31 = fix(4); s.a23 = fix(3);
    send_system(s);
    s = '0;
    s.a11 = fix(3); s.a22 = fix(3); s.a33 = fix(3);
    s.b1 = fix(1); s.b2 = fix(-1); s.b3 = fix(2);
    send_system(s);
  endtask

  task automatic test_singular;
    sys_t s;
    s = '0;
    send_system(s);
    s.a11 = fix(1); s.a12 = fix(2); s.a13 = fix(3); s.b1 = fix(4);
    s.a21 = fix(2); s.a22 = fix(4); s.a23 = fix(6); s.b2 = fix(8);
    s.a31 = fix(1); s.a32 = fix(1); s.a33 = fix(1); s.b3 = fix(1);
    send_system(s);
    s.b2 = fix(9);
    send_system(s);
    s = '0;
    s.b1 = fix(1);
    send_system(s);
  endtask

  task automatic test_saturation;
    sys_t s;
    s = '0;
    s.a11 = word_t'(1); s.a22 = word_t'(1); s.a33 = word_t'(1);
    s.b1 = word_t'(32'h7fffffff); s.b2 = word_t'(32'h80000000); s.b3 = word_t'(5);
    send_system(s);
    s.a11 = word_t'(-1);
    send_system(s);
    s.a11 = word_t'(32'h80000000); s.a22 = word_t'(32'h80000000);
    s.a33 = word_t'(32'h80000000);
    send_system(s);
    s = '0;
    s.a11 = word_t'(32'h7fffffff); s.a22 = word_t'(32'h7fffffff);
    s.a33 = word_t'(32'h7fffffff);
    s.b1 = word_t'(32'h80000000); s.b2 = word_t'(32'h7fffffff); s.b3 = word_t'(32'h80000000);
    send_system(s);
    s = {12{word_t'(32'h80000000)}};
    send_system(s);
    s = {12{word_t'(32'h7fffffff)}};
    send_system(s);
    s = {12{word_t'(-1)}};
    s.a11 = word_t'(1);
    send_system(s);
  endtask

  task automatic test_random_systems(int count);
    sys_t s;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 9);
      s = rand_system(pick % 4);
      if (pick == 8) begin
        s.a31 = s.a11; s.a32 = s.a12; s.a33 = s.a13; s.b3 = s.b1;
      end else if (pick == 9) begin
        s.a21 = s.a11; s.a22 = s.a12; s.a23 = s.a13;
      end
      if (n > count - 60) quiet = 1'b1;
      send_system(s);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_identity_and_simple();
    test_singular();
    test_saturation();
    test_random_systems(440);
    sys_ch.valid <= 1'b0;
    while (pending_solutions.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("cramer_three_by_three_solver_unit: match");
    end else begin
      $display("cramer_three_by_three_solver_unit: mismatch");
    end
    $finish;
  end
endmodule
